// ===== hw/rtl/perm_enum_pkg.sv =====
package perm_enum_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_MAX_N       = 8;
  localparam int DEF_VALUE_WIDTH = 8;

  // Fixed field widths of the item formats.
  localparam int INDEX_W  = 3;
  localparam int LENGTH_W = 4;

  // Width of the microprogram counter.
  localparam int PC_W = 4;

  // Datapath operations that one control word can request.
  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_SETTOP = 4'd1,   // depth pointer to the deepest level
    OP_POP    = 4'd2,   // free the current choice, search from the next index
    OP_TRY    = 4'd3,   // take the next free index at this depth if one exists
    OP_DEC    = 4'd4,   // back up one depth
    OP_FILL   = 4'd5,   // take the smallest free index at this depth
    OP_EMIT0  = 4'd6,   // depth pointer to the first position
    OP_EMIT   = 4'd7,   // send one element item
    OP_EXH    = 4'd8,   // send the exhausted status item
    OP_START  = 4'd9    // begin the first ordering
  } op_t;

  // Jump conditions; a false condition falls through to the next step.
  typedef enum logic [3:0] {
    CND_NEVER        = 4'd0,
    CND_ALWAYS       = 4'd1,
    CND_NOT_NEXT     = 4'd2,
    CND_EXH          = 4'd3,
    CND_NOT_STARTED  = 4'd4,
    CND_FOUND        = 4'd5,
    CND_PTR_ZERO     = 4'd6,
    CND_PTR_EQ_N     = 4'd7,
    CND_NOT_PTR_LAST = 4'd8
  } cond_t;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] PC_CHK_EXH = 4'd1;
  localparam logic [PC_W-1:0] PC_CHK_ST  = 4'd2;
  localparam logic [PC_W-1:0] PC_SETTOP  = 4'd3;
  localparam logic [PC_W-1:0] PC_POP     = 4'd4;
  localparam logic [PC_W-1:0] PC_TRY     = 4'd5;
  localparam logic [PC_W-1:0] PC_CHK_TOP = 4'd6;
  localparam logic [PC_W-1:0] PC_DEC     = 4'd7;
  localparam logic [PC_W-1:0] PC_CHK_END = 4'd8;
  localparam logic [PC_W-1:0] PC_FILL    = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT0   = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT    = 4'd11;
  localparam logic [PC_W-1:0] PC_DONE    = 4'd12;
  localparam logic [PC_W-1:0] PC_EXH     = 4'd13;
  localparam logic [PC_W-1:0] PC_START   = 4'd14;

  // One control word of the microprogram.
  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            wait_out;   // step holds until the output register is free
    logic            ready;      // step accepts an input item
  } ctrl_word_t;

  // Status from the datapath that the sequencer tests.
  typedef struct packed {
    logic hold;
    logic next_acc;
    logic exhausted;
    logic started;
    logic found;
    logic ptr_zero;
    logic ptr_eq_n;
    logic ptr_last;
  } flags_t;

  function automatic ctrl_word_t mk_word(op_t op, cond_t cond, logic [PC_W-1:0] target,
                                         logic wait_out, logic ready);
    ctrl_word_t w;
    w.op       = op;
    w.cond     = cond;
    w.target   = target;
    w.wait_out = wait_out;
    w.ready    = ready;
    return w;
  endfunction

  // The microprogram.
  function automatic ctrl_word_t rom_word(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      PC_WAIT:    w = mk_word(OP_NOP,    CND_NOT_NEXT,     PC_WAIT,    1'b0, 1'b1);
      PC_CHK_EXH: w = mk_word(OP_NOP,    CND_EXH,          PC_EXH,     1'b0, 1'b0);
      PC_CHK_ST:  w = mk_word(OP_NOP,    CND_NOT_STARTED,  PC_START,   1'b0, 1'b0);
      PC_SETTOP:  w = mk_word(OP_SETTOP, CND_NEVER,        PC_WAIT,    1'b0, 1'b0);
      PC_POP:     w = mk_word(OP_POP,    CND_NEVER,        PC_WAIT,    1'b0, 1'b0);
      PC_TRY:     w = mk_word(OP_TRY,    CND_FOUND,        PC_CHK_END, 1'b0, 1'b0);
      PC_CHK_TOP: w = mk_word(OP_NOP,    CND_PTR_ZERO,     PC_EXH,     1'b0, 1'b0);
      PC_DEC:     w = mk_word(OP_DEC,    CND_ALWAYS,       PC_POP,     1'b0, 1'b0);
      PC_CHK_END: w = mk_word(OP_NOP,    CND_PTR_EQ_N,     PC_EMIT0,   1'b0, 1'b0);
      PC_FILL:    w = mk_word(OP_FILL,   CND_NOT_PTR_LAST, PC_FILL,    1'b0, 1'b0);
      PC_EMIT0:   w = mk_word(OP_EMIT0,  CND_NEVER,        PC_WAIT,    1'b0, 1'b0);
      PC_EMIT:    w = mk_word(OP_EMIT,   CND_NOT_PTR_LAST, PC_EMIT,    1'b1, 1'b0);
      PC_DONE:    w = mk_word(OP_NOP,    CND_ALWAYS,       PC_WAIT,    1'b0, 1'b0);
      PC_EXH:     w = mk_word(OP_EXH,    CND_ALWAYS,       PC_WAIT,    1'b1, 1'b0);
      PC_START:   w = mk_word(OP_START,  CND_ALWAYS,       PC_FILL,    1'b0, 1'b0);
      default:    w = mk_word(OP_NOP,    CND_ALWAYS,       PC_WAIT,    1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/permutation_enumerator_core.sv =====
// Permutation enumerator. Load items (s_tuser 0) write one value into the store and restart
// the enumeration. Next items (s_tuser 1) step a backtracking search over store indices and
// return the next ordering of the first perm_length values as that many element items,
// position 0 first, the final one marked by m_tlast; once every ordering has been given, each
// next item gets one item with m_tuser 1. A microprogram of fifteen steps runs the search,
// one control word per cycle except while a step waits for the output register: a next item
// goes through dispatch, backs up from the deepest depth until a depth takes a new index,
// refills each deeper depth, sends each element and ends with bookkeeping. A waiting element
// that is not taken holds its step. The output register lets a new item be accepted while
// the last result still waits. Writing perm_length also restarts the enumeration; the length
// is only taken between requests.
module permutation_enumerator_core #(
  parameter int MAX_N       = perm_enum_pkg::DEF_MAX_N,
  parameter int VALUE_WIDTH = perm_enum_pkg::DEF_VALUE_WIDTH,
  localparam int DATA_W     = ((perm_enum_pkg::INDEX_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input items.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [DATA_W-1:0]                   s_tdata,   // elem_index, elem_value, zero pad
  input  logic                                s_tuser,   // req_type
  // Result items.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [DATA_W-1:0]                   m_tdata,   // out_position, out_value, zero pad
  output logic                                m_tuser,   // status
  output logic                                m_tlast,
  // Length register.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [perm_enum_pkg::LENGTH_W-1:0]  cfg_data
);
  import perm_enum_pkg::*;

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int NW = $clog2(MAX_N + 1);

  ctrl_word_t cw;
  flags_t     flags;

  logic [VALUE_WIDTH-1:0] value_store [MAX_N];
  logic [IW-1:0]          choice_stack [MAX_N];
  logic [MAX_N-1:0]       used;
  logic                   started;
  logic                   exhausted;
  logic [LENGTH_W-1:0]    perm_length;
  logic [NW-1:0]          ptr;
  logic [NW-1:0]          search_from;

  logic [NW-1:0]          n_eff;
  logic [IW-1:0]          ptr_idx;
  logic [IW-1:0]          cur;
  logic [IW-1:0]          cand;
  logic                   found;
  logic [NW-1:0]          from;
  logic                   out_free;
  logic                   exec;
  logic                   in_acc;
  logic                   load_acc;
  logic                   cfg_acc;

  logic [INDEX_W-1:0]     elem_index;
  logic [VALUE_WIDTH-1:0] elem_value;
  logic [IW-1:0]          ld_idx;
  logic [INDEX_W-1:0]     out_position;
  logic [VALUE_WIDTH-1:0] out_value;

  perm_enum_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  // Field unpacking and handshakes; the length is taken only in the idle step.
  assign elem_index = s_tdata[INDEX_W-1:0];
  assign elem_value = s_tdata[INDEX_W+VALUE_WIDTH-1:INDEX_W];
  assign ld_idx     = IW'(elem_index);
  assign s_tready   = cw.ready;
  assign cfg_ready  = cw.ready;
  assign in_acc     = s_tvalid && s_tready;
  assign load_acc   = in_acc && !s_tuser;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !m_tvalid || m_tready;
  assign exec       = !(cw.wait_out && !out_free);

  // Effective length: zero acts as one, above the store size acts as the store size.
  always_comb begin
    if (perm_length == '0) begin
      n_eff = NW'(1);
    end else if (32'(perm_length) > 32'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(perm_length);
    end
  end

  assign ptr_idx = ptr[IW-1:0];
  assign cur     = choice_stack[ptr_idx];

  // Smallest free index at or above the search start and below the length.
  assign from = (cw.op == OP_FILL) ? '0 : search_from;
  always_comb begin
    cand  = '0;
    found = 1'b0;
    for (int i = MAX_N - 1; i >= 0; i--) begin
      if (!used[i] && (32'(i) >= 32'(from)) && (32'(i) < 32'(n_eff))) begin
        cand  = IW'(i);
        found = 1'b1;
      end
    end
  end

  // Status for the sequencer.
  always_comb begin
    flags.hold      = !out_free;
    flags.next_acc  = in_acc && s_tuser;
    flags.exhausted = exhausted;
    flags.started   = started;
    flags.found     = found;
    flags.ptr_zero  = (ptr == '0);
    flags.ptr_eq_n  = (ptr == n_eff);
    flags.ptr_last  = (ptr == n_eff - NW'(1));
  end

  // Search state: mask, flags and depth pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= '0;
      started     <= 1'b0;
      exhausted   <= 1'b0;
      perm_length <= LENGTH_W'(1);
      ptr         <= '0;
    end else if (cfg_acc) begin
      perm_length <= cfg_data;
      used        <= '0;
      started     <= 1'b0;
      exhausted   <= 1'b0;
    end else if (load_acc) begin
      used      <= '0;
      started   <= 1'b0;
      exhausted <= 1'b0;
    end else if (exec) begin
      unique case (cw.op)
        OP_SETTOP: ptr <= n_eff - NW'(1);
        OP_POP:    used <= used & ~(MAX_N'(1) << cur);
        OP_TRY: begin
          if (found) begin
            used <= used | (MAX_N'(1) << cand);
            ptr  <= ptr + NW'(1);
          end
        end
        OP_DEC: ptr <= ptr - NW'(1);
        OP_FILL: begin
          used <= used | (MAX_N'(1) << cand);
          ptr  <= ptr + NW'(1);
        end
        OP_EMIT0: ptr <= '0;
        OP_EMIT:  ptr <= ptr + NW'(1);
        OP_EXH: begin
          exhausted <= 1'b1;
          used      <= '0;
        end
        OP_START: begin
          used    <= '0;
          ptr     <= '0;
          started <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Choice stack and search start; payload, no reset needed.
  always_ff @(posedge clk) begin
    if (exec && !cfg_acc && !load_acc) begin
      if (cw.op == OP_POP) begin
        search_from <= NW'(cur) + NW'(1);
      end
      if ((cw.op == OP_TRY && found) || cw.op == OP_FILL) begin
        choice_stack[ptr_idx] <= cand;
      end
    end
  end

  // Value store writes; an index beyond the store writes nothing.
  always_ff @(posedge clk) begin
    if (load_acc && (32'(elem_index) < 32'(MAX_N))) begin
      value_store[ld_idx] <= elem_value;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec && (cw.op == OP_EMIT || cw.op == OP_EXH)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload, with the store read registered here.
  always_ff @(posedge clk) begin
    if (exec && cw.op == OP_EMIT) begin
      m_tuser      <= 1'b0;
      out_position <= INDEX_W'(ptr);
      out_value    <= value_store[cur];
      m_tlast      <= flags.ptr_last;
    end else if (exec && cw.op == OP_EXH) begin
      m_tuser      <= 1'b1;
      out_position <= '0;
      out_value    <= '0;
      m_tlast      <= 1'b1;
    end
  end

  assign m_tdata = DATA_W'({out_value, out_position});

`ifndef NO_ASSERTIONS
  // An element is only sent from a depth inside the ordering.
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT) |-> (ptr < n_eff))
    else $error("element sent beyond the ordering length");

  // A complete ordering uses exactly as many indices as its length.
  a_mask_full: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT) |-> ($countones(used) == 32'(n_eff)))
    else $error("used mask does not match the ordering length");

  // The exhausted status item always closes its request.
  a_exh_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("exhausted item not marked last");

  // After the exhausted item the search stays exhausted until a restart.
  a_exh_sticky: assert property (@(posedge clk) disable iff (rst)
    (exhausted && !cfg_acc && !load_acc) |=> exhausted)
    else $error("exhausted flag dropped without a restart");
`endif

endmodule

// ===== hw/rtl/perm_enum_seq.sv =====
module perm_enum_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  perm_enum_pkg::flags_t     flags,
  output perm_enum_pkg::ctrl_word_t cw
);
  import perm_enum_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  // Control word of the current step.
  assign cw = rom_word(pc);

  // Jump condition selected by the control word.
  always_comb begin
    unique case (cw.cond)
      CND_NEVER:        take = 1'b0;
      CND_ALWAYS:       take = 1'b1;
      CND_NOT_NEXT:     take = !flags.next_acc;
      CND_EXH:          take = flags.exhausted;
      CND_NOT_STARTED:  take = !flags.started;
      CND_FOUND:        take = flags.found;
      CND_PTR_ZERO:     take = flags.ptr_zero;
      CND_PTR_EQ_N:     take = flags.ptr_eq_n;
      CND_NOT_PTR_LAST: take = !flags.ptr_last;
      default:          take = 1'b1;
    endcase
  end

  // Step counter: hold, jump or fall through.
  always_comb begin
    if (cw.wait_out && flags.hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
